// ----- design/minv_pkg.sv -----
package minv_pkg;

  // element and store geometry
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = 4;
  localparam int OP_W     = 100;   // minors and cofactors, sign-extended
  localparam int OP_DEPTH = 28;    // 12 minors, then 16 cofactors
  localparam int OP_AW    = 5;
  localparam int COF_BASE = 12;

  // multiplier and accumulator widths
  localparam int CHUNK_W  = 32;
  localparam int B_W      = 36;    // top chunk of a cofactor is 36 bits signed
  localparam int PROD_W   = ELEM_W + B_W;
  localparam int ACC_W    = 134;
  localparam int DMAG_W   = 133;

  // controller to datapath commands
  typedef struct packed {
    logic              mac_vld;
    logic [IDX_W-1:0]  a_addr;
    logic [IDX_W-1:0]  b_addr;
    logic              b_elem;
    logic [OP_AW-1:0]  op_addr;
    logic [1:0]        chunk;
    logic              chunk_top;
    logic              neg;
    logic              first;
    logic              wr;
    logic              is_det;
    logic [OP_AW-1:0]  dest;
    logic              prep_abs;
    logic              prep_rnd;
    logic              div_abs;
    logic              div_start;
    logic              res_load;
    logic [IDX_W-1:0]  res_idx;
    logic              res_last;
  } minv_cmd_t;

  // datapath status
  typedef struct packed {
    logic pipe_busy;
    logic div_fin;
    logic out_free;
    logic sing;
  } minv_sts_t;

  // index of a column pair among (01,02,03,12,13,23)
  function automatic logic [2:0] pair_index(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    unique case ({lo, hi})
      4'b0001: return 3'd0;
      4'b0010: return 3'd1;
      4'b0011: return 3'd2;
      4'b0110: return 3'd3;
      4'b0111: return 3'd4;
      4'b1011: return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  // columns {u, v} of a pair index
  function automatic logic [3:0] pair_cols(input logic [2:0] pp);
    unique case (pp)
      3'd0:    return 4'b0001;
      3'd1:    return 4'b0010;
      3'd2:    return 4'b0011;
      3'd3:    return 4'b0110;
      3'd4:    return 4'b0111;
      3'd5:    return 4'b1011;
      default: return 4'b0001;
    endcase
  endfunction

  // magnitude plus sign to saturated 32-bit two's complement
  function automatic logic [31:0] sat_mag(input logic big, input logic [31:0] mag,
                                          input logic neg);
    if (neg) begin
      if (big || (mag[31] && (|mag[30:0]))) return 32'h8000_0000;
      return 32'd0 - mag;
    end
    if (big || mag[31]) return 32'h7FFF_FFFF;
    return mag;
  endfunction

endpackage

// ----- design/minv_div.sv -----
module minv_div import minv_pkg::*; #(
  parameter int NUM_W = 168,
  parameter int DEN_W = 134
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             fin,
  output logic             ovf,
  output logic [31:0]      q
);

  localparam int HI_W  = NUM_W - 32;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [31:0]      q_r;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic             init_r;
  logic             fin_r;
  logic             ovf_r;

  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // quotient of 2^32 or more is only flagged; otherwise one bit per cycle
  assign hi_ext  = CMP_W'(num_r[NUM_W-1:32]);
  assign den_ext = CMP_W'(den_r);
  assign trial   = {rem_r, num_r[cnt_r]};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      init_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (start) begin
      num_r  <= num;
      den_r  <= den;
      run_r  <= 1'b1;
      init_r <= 1'b1;
      fin_r  <= 1'b0;
      ovf_r  <= 1'b0;
      q_r    <= '0;
    end else if (run_r) begin
      if (init_r) begin
        if (hi_ext >= den_ext) begin
          ovf_r <= 1'b1;
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end else begin
          rem_r  <= hi_ext[DEN_W-1:0];
          init_r <= 1'b0;
          cnt_r  <= 5'd31;
        end
      end else begin
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r   <= {q_r[30:0], ge};
        if (cnt_r == 5'd0) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign fin = fin_r;
  assign ovf = ovf_r;
  assign q   = q_r;

endmodule

// ----- design/minv_ctrl.sv -----
module minv_ctrl import minv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_compute,
  output logic      in_stall,
  input  minv_sts_t sts,
  output minv_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'h001,
    S_MINOR    = 12'h002,
    S_COF      = 12'h004,
    S_DET      = 12'h008,
    S_DRAIN    = 12'h010,
    S_PREP_ABS = 12'h020,
    S_PREP_RND = 12'h040,
    S_DRD      = 12'h080,
    S_DABS     = 12'h100,
    S_DSTART   = 12'h200,
    S_DWAIT    = 12'h400,
    S_DOUT     = 12'h800
  } state_t;

  state_t           state_r, state_nxt;
  state_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [IDX_W-1:0] kout_r, kout_nxt;

  // minor phase decode
  logic             mh;
  logic [3:0]       mpw;
  logic [2:0]       mpp;
  logic [3:0]       muv;
  // cofactor phase decode
  logic [1:0]       cr, cc, ccol;
  logic [2:0]       cpair;

  always_comb begin
    mh    = idx_r >= 4'd6;
    mpw   = idx_r - 4'd6;
    mpp   = mh ? mpw[2:0] : idx_r[2:0];
    muv   = pair_cols(mpp);
    cr    = idx_r[3:2];
    cc    = idx_r[1:0];
    ccol  = (sub_r < cc) ? sub_r : sub_r + 2'd1;
    cpair = 3'd5 - pair_index(cc, ccol);
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    ch_nxt    = ch_r;
    kout_nxt  = kout_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_compute) begin
          state_nxt = S_MINOR;
          idx_nxt   = '0;
          sub_nxt   = '0;
          ch_nxt    = '0;
        end
      end
      // 2x2 minors: two products each
      S_MINOR: begin
        cmd.mac_vld   = 1'b1;
        cmd.b_elem    = 1'b1;
        cmd.chunk_top = 1'b1;
        cmd.a_addr    = sub_r[0] ? {mh, 1'b0, muv[1:0]} : {mh, 1'b0, muv[3:2]};
        cmd.b_addr    = sub_r[0] ? {mh, 1'b1, muv[3:2]} : {mh, 1'b1, muv[1:0]};
        cmd.neg       = sub_r[0];
        cmd.first     = !sub_r[0];
        cmd.wr        = sub_r[0];
        cmd.dest      = {1'b0, idx_r};
        if (sub_r[0]) begin
          sub_nxt = '0;
          if (idx_r == 4'd11) begin
            idx_nxt   = '0;
            state_nxt = S_DRAIN;
            phase_nxt = S_COF;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end else begin
          sub_nxt = 2'd1;
        end
      end
      // cofactors: three element-times-minor terms, two chunks each
      S_COF: begin
        cmd.mac_vld   = 1'b1;
        cmd.a_addr    = {cr ^ 2'b01, ccol};
        cmd.op_addr   = {2'b00, cpair} + (cr[1] ? 5'd0 : 5'd6);
        cmd.chunk     = {1'b0, ch_r[0]};
        cmd.chunk_top = ch_r[0];
        cmd.neg       = cr[0] ^ cc[0] ^ sub_r[0];
        cmd.first     = (sub_r == 2'd0) && !ch_r[0];
        cmd.wr        = (sub_r == 2'd2) && ch_r[0];
        cmd.dest      = 5'(COF_BASE) + {1'b0, idx_r};
        if (ch_r[0]) begin
          ch_nxt = '0;
          if (sub_r == 2'd2) begin
            sub_nxt = '0;
            if (idx_r == 4'd15) begin
              idx_nxt   = '0;
              state_nxt = S_DRAIN;
              phase_nxt = S_DET;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end else begin
          ch_nxt = 2'd1;
        end
      end
      // determinant: first row against its cofactors, three chunks each
      S_DET: begin
        cmd.mac_vld   = 1'b1;
        cmd.a_addr    = {2'b00, idx_r[1:0]};
        cmd.op_addr   = 5'(COF_BASE) + {3'b000, idx_r[1:0]};
        cmd.chunk     = ch_r;
        cmd.chunk_top = ch_r == 2'd2;
        cmd.first     = (idx_r[1:0] == 2'd0) && (ch_r == 2'd0);
        cmd.is_det    = (idx_r[1:0] == 2'd3) && (ch_r == 2'd2);
        if (ch_r == 2'd2) begin
          ch_nxt = '0;
          if (idx_r[1:0] == 2'd3) begin
            idx_nxt   = '0;
            state_nxt = S_DRAIN;
            phase_nxt = S_PREP_ABS;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = phase_r;
      end
      S_PREP_ABS: begin
        cmd.prep_abs = 1'b1;
        state_nxt    = S_PREP_RND;
      end
      S_PREP_RND: begin
        cmd.prep_rnd = 1'b1;
        kout_nxt     = '0;
        state_nxt    = sts.sing ? S_DOUT : S_DRD;
      end
      // transposed cofactor read for output (i,j)
      S_DRD: begin
        cmd.op_addr = 5'(COF_BASE) + {1'b0, kout_r[1:0], kout_r[3:2]};
        state_nxt   = S_DABS;
      end
      S_DABS: begin
        cmd.div_abs = 1'b1;
        state_nxt   = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_fin) state_nxt = S_DOUT;
      end
      S_DOUT: begin
        cmd.res_idx  = kout_r;
        cmd.res_last = kout_r == 4'd15;
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          if (kout_r == 4'd15) begin
            kout_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            kout_nxt  = kout_r + 4'd1;
            state_nxt = sts.sing ? S_DOUT : S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= S_IDLE;
      idx_r   <= '0;
      sub_r   <= '0;
      ch_r    <= '0;
      kout_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
      ch_r    <= ch_nxt;
      kout_r  <= kout_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// ----- design/minv_dp.sv -----
module minv_dp import minv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_row,
  input  logic [1:0]        in_col,
  input  logic [ELEM_W-1:0] in_value,
  input  minv_cmd_t         cmd,
  output minv_sts_t         sts,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        out_row,
  output logic [1:0]        out_col,
  output logic [31:0]       out_inv_value,
  output logic [31:0]       out_determinant,
  output logic              out_singular,
  output logic              out_last
);

  localparam int NUM_W = 2 * FRAC_BITS + 136;
  localparam int DEN_W = DMAG_W + 1;
  localparam int RSH   = 3 * FRAC_BITS;
  localparam logic [DMAG_W:0] RND_HALF = {{DMAG_W{1'b0}}, 1'b1} << (RSH - 1);

  typedef struct packed {
    logic             vld;
    logic             b_elem;
    logic [1:0]       chunk;
    logic             chunk_top;
    logic             neg;
    logic             first;
    logic             wr;
    logic             is_det;
    logic [OP_AW-1:0] dest;
  } mac_ctl_t;

  // matrix store, two registered read ports, valid bits for reset
  logic [ELEM_W-1:0] mat_mem [16];
  logic [15:0]       mat_vld_r;
  logic [ELEM_W-1:0] a_rd_r;
  logic [ELEM_W-1:0] b_rd_r;
  logic              ld;

  assign ld = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (ld) mat_mem[{in_row, in_col}] <= in_value;
    a_rd_r <= mat_vld_r[cmd.a_addr] ? mat_mem[cmd.a_addr] : '0;
    b_rd_r <= mat_vld_r[cmd.b_addr] ? mat_mem[cmd.b_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_vld_r <= '0;
    end else if (ld) begin
      mat_vld_r[{in_row, in_col}] <= 1'b1;
    end
  end

  // minor / cofactor store
  logic [OP_W-1:0]  op_mem [OP_DEPTH];
  logic [OP_W-1:0]  op_rd_r;
  mac_ctl_t         s1_r, s2_r;
  logic signed [ACC_W-1:0] acc_r, det_r, ps_ext, shifted, base, sum;

  always_ff @(posedge clk) begin
    if (s2_r.vld && s2_r.wr) op_mem[s2_r.dest] <= sum[OP_W-1:0];
    op_rd_r <= op_mem[cmd.op_addr];
  end

  // stage 1: operand select and multiply
  logic signed [ELEM_W-1:0] a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    a_op = $signed(a_rd_r);
    if (s1_r.b_elem) begin
      b_op = B_W'($signed(b_rd_r));
    end else if (s1_r.chunk_top) begin
      b_op = op_rd_r[CHUNK_W*s1_r.chunk +: B_W];
    end else begin
      b_op = {{(B_W-CHUNK_W){1'b0}}, op_rd_r[CHUNK_W*s1_r.chunk +: CHUNK_W]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
  end

  // stage 2: shift by chunk and accumulate
  always_comb begin
    ps_ext  = ACC_W'(prod_r);
    shifted = ps_ext << {s2_r.chunk, 5'b00000};
    base    = s2_r.first ? '0 : acc_r;
    sum     = s2_r.neg ? base - shifted : base + shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r.vld       <= cmd.mac_vld;
      s1_r.b_elem    <= cmd.b_elem;
      s1_r.chunk     <= cmd.chunk;
      s1_r.chunk_top <= cmd.chunk_top;
      s1_r.neg       <= cmd.neg;
      s1_r.first     <= cmd.first;
      s1_r.wr        <= cmd.wr;
      s1_r.is_det    <= cmd.is_det;
      s1_r.dest      <= cmd.dest;
      s2_r           <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_r.vld) begin
      acc_r <= sum;
      if (s2_r.is_det) det_r <= sum;
    end
  end

  // determinant magnitude, singular flag, rounded output
  logic [DMAG_W-1:0] dmag_r;
  logic              dneg_r;
  logic              sing_r;
  logic [31:0]       detq_r;
  logic [DMAG_W:0]   rsum;
  logic [DMAG_W:0]   dq;
  logic signed [ACC_W-1:0] det_abs;

  assign det_abs = det_r[ACC_W-1] ? -det_r : det_r;
  assign rsum    = {1'b0, dmag_r} + RND_HALF;
  assign dq      = rsum >> RSH;

  always_ff @(posedge clk) begin
    if (cmd.prep_abs) begin
      dneg_r <= det_r[ACC_W-1];
      dmag_r <= det_abs[DMAG_W-1:0];
      sing_r <= det_r == '0;
    end
    if (cmd.prep_rnd) begin
      detq_r <= sat_mag(|dq[DMAG_W:32], dq[31:0], dneg_r);
    end
  end

  // numerator and denominator for one inverse element
  logic [OP_W-1:0]  a_mag_r;
  logic             a_neg_r;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             div_fin;
  logic             div_ovf;
  logic [31:0]      div_q;

  always_ff @(posedge clk) begin
    if (cmd.div_abs) begin
      a_neg_r <= op_rd_r[OP_W-1];
      a_mag_r <= op_rd_r[OP_W-1] ? (OP_W'(0) - op_rd_r) : op_rd_r;
    end
  end

  assign num = (NUM_W'(a_mag_r) << (2 * FRAC_BITS + 1)) + NUM_W'(dmag_r);
  assign den = {dmag_r, 1'b0};

  minv_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .fin   (div_fin),
    .ovf   (div_ovf),
    .q     (div_q)
  );

  // output word register
  logic        out_valid_r;
  logic [1:0]  out_row_r;
  logic [1:0]  out_col_r;
  logic [31:0] out_inv_r;
  logic [31:0] out_det_r;
  logic        out_sing_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_row_r  <= cmd.res_idx[3:2];
      out_col_r  <= cmd.res_idx[1:0];
      out_inv_r  <= sing_r ? '0 : sat_mag(div_ovf, div_q, a_neg_r ^ dneg_r);
      out_det_r  <= detq_r;
      out_sing_r <= sing_r;
      out_last_r <= cmd.res_last;
    end
  end

  assign sts.pipe_busy = s1_r.vld || s2_r.vld;
  assign sts.div_fin   = div_fin;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.sing      = sing_r;

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_inv_value   = out_inv_r;
  assign out_determinant = out_det_r;
  assign out_singular    = out_sing_r;
  assign out_last        = out_last_r;

endmodule

// ----- design/matrix_inverse_4x4.sv -----
// Loads write one word each; the store accepts a load every cycle while idle.
// A compute word runs multiply-accumulate on one shared 32x36 multiplier (24 minor,
// 96 cofactor, 12 determinant products, 3 drains, 2 prep).
// Each of the 16 results then takes a cofactor read, an absolute value and the bit-serial
// divider; a singular matrix emits its 16 results one per cycle unless out_stall holds them.
// Reset clears the matrix store to zero (per-entry valid bits) and the control.
module matrix_inverse_4x4 import minv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic [31:0] in_value,
  input  logic        in_compute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic [31:0] out_inv_value,
  output logic [31:0] out_determinant,
  output logic        out_singular,
  output logic        out_last
);

  minv_cmd_t cmd;
  minv_sts_t sts;

  minv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_compute (in_compute),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  minv_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_inv_value   (out_inv_value),
    .out_determinant (out_determinant),
    .out_singular    (out_singular),
    .out_last        (out_last)
  );

  // a compute word starts a run
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_compute |=> in_stall)
    else $error("compute word did not start a run");

  // singular words carry zero element and zero determinant
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_value == 32'd0 && out_determinant == 32'd0)
    else $error("singular word with nonzero payload");

  // last word of a run is element (3,3)
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row == 2'd3 && out_col == 2'd3)
    else $error("last flag on wrong element");

endmodule

// ----- tb/matrix_inverse_4x4_test.sv -----
module matrix_inverse_4x4_test;

  localparam int FRAC = 16;
  localparam int IDLE_PCT = 29;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int HOLD_CYCLES = 500;

  typedef logic signed [191:0] swide_t;
  typedef logic [191:0] uwide_t;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        compute;
  } load_word_t;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] inv;
    logic [31:0] det;
    logic        sing;
    logic        last;
  } inv_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_row;
  logic [1:0]  in_col;
  logic [31:0] in_value;
  logic        in_compute;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic [31:0] out_inv_value;
  logic [31:0] out_determinant;
  logic        out_singular;
  logic        out_last;

  load_word_t  load_queue[$];
  inv_word_t   inverse_queue[$];
  logic [31:0] shadow_store[16];
  int          fail_count;
  int          cycle_count;
  int          idle_cycles;
  int          results_seen;
  int          hold_left;
  bit          hold_done;

  matrix_inverse_4x4 #(.FRAC_BITS(FRAC)) uut (.*);

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // no random idling during this window
  function automatic bit quiet_window();
    return (cycle_count >= 3000) && (cycle_count < 9000);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", field, got, want,
             results_seen);
    fail_count++;
  endtask

  function automatic swide_t elem_at(input int r, input int c);
    swide_t e;
    e = $signed(shadow_store[r * 4 + c]);
    return e;
  endfunction

  // exact signed cofactor of (r,c)
  function automatic swide_t cofactor_of(input int r, input int c);
    int rr[3];
    int cc[3];
    int n;
    swide_t m[3][3];
    swide_t t;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != r) begin rr[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != c) begin cc[n] = i; n++; end
    for (int i = 0; i < 9; i++) m[i / 3][i % 3] = elem_at(rr[i / 3], cc[i % 3]);
    t = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((r + c) % 2 == 1) ? -t : t;
  endfunction

  function automatic logic [31:0] saturate(input uwide_t mag, input bit neg);
    if (neg) begin
      if (mag > 192'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 192'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // store the word, and on a compute word queue the 16 inverse words
  task automatic predict_inverse(input load_word_t w);
    swide_t cof[4][4];
    swide_t det;
    swide_t a;
    uwide_t dmag;
    uwide_t amag;
    uwide_t num;
    logic [31:0] detq;
    bit sing;
    bit dneg;
    inv_word_t r;
    shadow_store[{w.row, w.col}] = w.value;
    if (!w.compute) return;
    for (int k = 0; k < 16; k++) cof[k / 4][k % 4] = cofactor_of(k / 4, k % 4);
    det = '0;
    for (int k = 0; k < 4; k++) det = det + elem_at(0, k) * cof[0][k];
    sing = (det == 0);
    dneg = det < 0;
    dmag = dneg ? uwide_t'(-det) : uwide_t'(det);
    detq = saturate((dmag + (uwide_t'(1) << (3 * FRAC - 1))) >> (3 * FRAC), dneg);
    for (int k = 0; k < 16; k++) begin
      r.row = 2'(k / 4);
      r.col = 2'(k % 4);
      r.inv = '0;
      if (!sing) begin
        a = cof[k % 4][k / 4];
        amag = (a < 0) ? uwide_t'(-a) : uwide_t'(a);
        num = (amag << (2 * FRAC + 1)) + dmag;
        r.inv = saturate(num / (dmag << 1), (a < 0) != dneg);
      end
      r.det = detq;
      r.sing = sing;
      r.last = (k == 15);
      inverse_queue.push_back(r);
    end
  endtask

  function automatic logic [31:0] rand_value();
    int m;
    m = $urandom_range(9);
    case (m)
      0, 1, 2: return $urandom();
      3:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4:       return $urandom_range(7) - 4;
      default: return ($urandom_range(16) - 8) << FRAC | ($urandom() & 32'hFFFF);
    endcase
  endfunction

  task automatic queue_load(input int r, input int c, input logic [31:0] v,
                            input bit comp);
    load_word_t w;
    w.row = 2'(r);
    w.col = 2'(c);
    w.value = v;
    w.compute = comp;
    load_queue.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    load_word_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w.row = in_row;
        w.col = in_col;
        w.value = in_value;
        w.compute = in_compute;
        predict_inverse(w);
      end
      if (!in_valid || !in_stall) begin
        if (load_queue.size() > 0 && (quiet_window() || $urandom_range(99) >= IDLE_PCT))
        begin
          w = load_queue.pop_front();
          in_valid <= 1'b1;
          in_row <= w.row;
          in_col <= w.col;
          in_value <= w.value;
          in_compute <= w.compute;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, drives stall with one long hold-off
  always @(posedge clk) begin
    inv_word_t e;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (inverse_queue.size() == 0) begin
          report_mismatch("unexpected word", {28'd0, out_row, out_col}, 32'd0);
        end else begin
          e = inverse_queue.pop_front();
          if (out_row !== e.row) report_mismatch("row", 32'(out_row), 32'(e.row));
          if (out_col !== e.col) report_mismatch("col", 32'(out_col), 32'(e.col));
          if (out_inv_value !== e.inv) report_mismatch("inv_value", out_inv_value, e.inv);
          if (out_determinant !== e.det)
            report_mismatch("determinant", out_determinant, e.det);
          if (out_singular !== e.sing)
            report_mismatch("singular", 32'(out_singular), 32'(e.sing));
          if (out_last !== e.last) report_mismatch("last", 32'(out_last), 32'(e.last));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_window() && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int order[16];
    int n;
    int tmp;
    int j;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    in_compute = 1'b0;
    out_stall = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    idle_cycles = 0;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    for (int i = 0; i < 16; i++) shadow_store[i] = '0;

    // directed: zero matrix straight from reset is singular
    queue_load(0, 0, 32'd0, 1'b1);
    // identity
    for (int i = 0; i < 4; i++) queue_load(i, i, 32'd1 << FRAC, i == 3);
    // tiny nonzero determinant: inverse saturates, determinant reads zero
    for (int i = 0; i < 4; i++) queue_load(i, i, 32'd1, i == 3);
    // extremes in the first row
    queue_load(0, 0, 32'h7FFF_FFFF, 1'b0);
    queue_load(0, 1, 32'h8000_0000, 1'b0);
    queue_load(0, 2, 32'hFFFF_FFFF, 1'b0);
    queue_load(0, 3, 32'h8000_0000, 1'b1);
    // negative diagonal
    for (int i = 0; i < 4; i++) queue_load(3 - i, 3 - i, 32'hFFFE_0000, i == 3);

    // random: mostly full or partial matrix loads ending in compute, some noise
    n = 0;
    while (n < 250) begin
      if ($urandom_range(9) < 7) begin
        for (int i = 0; i < 16; i++) order[i] = i;
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        tmp = $urandom_range(3) == 0 ? $urandom_range(1, 15) : 16;
        for (int i = 0; i < tmp; i++) begin
          queue_load(order[i] / 4, order[i] % 4, rand_value(), i == tmp - 1);
          n++;
        end
      end else begin
        queue_load($urandom_range(3), $urandom_range(3), rand_value(),
                   $urandom_range(3) == 0);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (load_queue.size() == 0 && !in_valid);
    wait (inverse_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && inverse_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- matrix_inverse_4x4.f -----
design/minv_pkg.sv
design/minv_div.sv
design/minv_ctrl.sv
design/minv_dp.sv
design/matrix_inverse_4x4.sv
tb/matrix_inverse_4x4_test.sv
